### src/nnsa_pkg.sv
// shared constants, types and helpers for the nearest neighbor scale address core
`timescale 1ns / 1ps

package nnsa_pkg;

   localparam int COORD_W     = 14;
   localparam int DIM_W       = 15;
   localparam int PB_W        = 4;
   localparam int OFF_W       = 31;
   localparam int PROD_W      = COORD_W + DIM_W;
   localparam int QUO_W       = DIM_W;
   localparam int LIN_W       = PROD_W + 1;
   localparam int SLIN_W      = 2 * DIM_W + 1;
   localparam int CSR_IDX_W   = 3;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 96;
   localparam int MAX_DIM_DEF = 16384;
   localparam int PB_MAX      = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH   = 3'd0,
      CSR_SRC_HEIGHT  = 3'd1,
      CSR_DST_WIDTH   = 3'd2,
      CSR_DST_HEIGHT  = 3'd3,
      CSR_PIXEL_BYTES = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic               err;
      logic [COORD_W-1:0] ox;
      logic [COORD_W-1:0] oy;
   } head_type;

   typedef struct packed {
      logic               err;
      logic [COORD_W-1:0] ox;
      logic [PROD_W-1:0]  px;
      logic [PROD_W-1:0]  py;
      logic [PROD_W-1:0]  dmul;
   } mul_type;

   typedef struct packed {
      logic             err;
      logic [DIM_W-1:0] rx;
      logic [QUO_W-1:0] qx;
      logic [DIM_W-1:0] ry;
      logic [QUO_W-1:0] qy;
      logic [LIN_W-1:0] lin;
      logic [OFF_W-1:0] doff;
   } div_type;

   typedef struct packed {
      logic              err;
      logic [QUO_W-1:0]  sx;
      logic [QUO_W-1:0]  sy;
      logic [SLIN_W-1:0] slin;
      logic [OFF_W-1:0]  doff;
   } tail_type;

   typedef struct packed {
      logic               err;
      logic [COORD_W-1:0] sx;
      logic [COORD_W-1:0] sy;
      logic [OFF_W-1:0]   soff;
      logic [OFF_W-1:0]   doff;
   } out_type;

   typedef struct packed {
      logic [DIM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } div_step_type;

   // one restoring division step, remainder stays below the divisor
   function automatic div_step_type div_step(logic [DIM_W-1:0] rem, logic [QUO_W-1:0] quo,
                                             logic [DIM_W-1:0] dvs);
      logic [DIM_W:0] trial;
      logic           ge;
      div_step_type   res;
      trial   = {rem, quo[QUO_W-1]};
      ge      = (trial >= {1'b0, dvs});
      res.rem = ge ? DIM_W'(trial - {1'b0, dvs}) : trial[DIM_W-1:0];
      res.quo = {quo[QUO_W-2:0], ge};
      return res;
   endfunction

endpackage

### src/nearest_neighbor_scale_address_core.sv
// nearest neighbor scaling: source pixel and byte offsets, one pixel per clock unless stalled
//
// req channel carries one destination coordinate per item (out_x, out_y).
// rsp channel returns one item per request, in order: source column and row, source and
// destination byte offsets, and coord_error in rsp_tuser. a coordinate outside the
// destination size gives coord_error = 1 with every other field zero.
// csr channel writes the dimension and bytes-per-pixel registers; csr_ready is always high.
// write them only while no item is in flight.
// an item passes 21 register stages from req acceptance to rsp_tvalid (head, mul, divider, smul,
// sadd, out); throughput is one item per cycle while rsp_tready does not stall the output.
// the two quotients come from a 15-stage restoring divider, one quotient bit per stage,
// which sets most of the latency.
// reset empties the pipeline and loads width/height 1 and 4 bytes per pixel.
// when rsp_tready is low the output holds; earlier stages keep moving into empty slots,
// so req_tready drops only once every stage holds an item.
`timescale 1ns / 1ps

module nearest_neighbor_scale_address_core
   import nnsa_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // out_x, out_y, zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // src_x, src_y, src_offset, dst_offset, zero pad
   output logic                  rsp_tuser,   // coord_error
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DIM_W-1:0]      csr_data
);

   localparam int ST_IN   = 0;
   localparam int ST_MUL  = 1;
   localparam int ST_DIV  = 2;
   localparam int ST_SMUL = ST_DIV + QUO_W + 1;
   localparam int ST_SADD = ST_SMUL + 1;
   localparam int ST_OUT  = ST_SADD + 1;
   localparam int NS      = ST_OUT + 1;

   logic [DIM_W-1:0] src_width_ff, src_height_ff, dst_width_ff, dst_height_ff;
   logic [PB_W-1:0]  pixel_bytes_ff;
   logic [DIM_W-1:0] sw_eff, sh_eff, dw_eff, dh_eff;
   logic [PB_W-1:0]  pb_eff;

   logic [NS-1:0] vld_ff, vld_in, en;

   head_type head_ff, head_in;
   mul_type  mul_ff, mul_in;
   div_type  div_ff [QUO_W+1];
   div_type  div_in [QUO_W+1];
   tail_type smul_ff, smul_in, sadd_ff, sadd_in;
   out_type  out_ff, out_in;

   function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff   <= DIM_W'(1);
         src_height_ff  <= DIM_W'(1);
         dst_width_ff   <= DIM_W'(1);
         dst_height_ff  <= DIM_W'(1);
         pixel_bytes_ff <= PB_W'(4);
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_SRC_WIDTH:   src_width_ff   <= csr_data;
            CSR_SRC_HEIGHT:  src_height_ff  <= csr_data;
            CSR_DST_WIDTH:   dst_width_ff   <= csr_data;
            CSR_DST_HEIGHT:  dst_height_ff  <= csr_data;
            CSR_PIXEL_BYTES: pixel_bytes_ff <= csr_data[PB_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      sw_eff = eff_dim(src_width_ff);
      sh_eff = eff_dim(src_height_ff);
      dw_eff = eff_dim(dst_width_ff);
      dh_eff = eff_dim(dst_height_ff);
      if (pixel_bytes_ff == '0) begin
         pb_eff = PB_W'(1);
      end else if (pixel_bytes_ff > PB_W'(PB_MAX)) begin
         pb_eff = PB_W'(PB_MAX);
      end else begin
         pb_eff = pixel_bytes_ff;
      end
   end

   // stage enables, a stage moves when empty or when the next one moves
   always_comb begin
      en[NS-1] = !vld_ff[NS-1] || rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in[0] = en[0] ? req_tvalid : vld_ff[0];
      for (int k = 1; k < NS; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = en[ST_IN];

   // input capture and range check
   always_comb begin
      head_in.ox  = req_tdata[COORD_W-1:0];
      head_in.oy  = req_tdata[2*COORD_W-1:COORD_W];
      head_in.err = ({1'b0, head_in.ox} >= dw_eff) || ({1'b0, head_in.oy} >= dh_eff);
   end

   // products
   always_comb begin
      mul_in.err  = head_ff.err;
      mul_in.ox   = head_ff.ox;
      mul_in.px   = PROD_W'(head_ff.ox) * PROD_W'(sw_eff);
      mul_in.py   = PROD_W'(head_ff.oy) * PROD_W'(sh_eff);
      mul_in.dmul = PROD_W'(head_ff.oy) * PROD_W'(dw_eff);
   end

   // divider setup and destination linear index
   always_comb begin
      div_in[0].err  = mul_ff.err;
      div_in[0].rx   = {1'b0, mul_ff.px[PROD_W-1:QUO_W]};
      div_in[0].qx   = mul_ff.px[QUO_W-1:0];
      div_in[0].ry   = {1'b0, mul_ff.py[PROD_W-1:QUO_W]};
      div_in[0].qy   = mul_ff.py[QUO_W-1:0];
      div_in[0].lin  = LIN_W'(mul_ff.dmul) + LIN_W'(mul_ff.ox);
      div_in[0].doff = '0;
   end

   always_ff @(posedge clock) begin
      if (en[ST_IN]) begin
         head_ff <= head_in;
      end
      if (en[ST_MUL]) begin
         mul_ff <= mul_in;
      end
      if (en[ST_DIV]) begin
         div_ff[0] <= div_in[0];
      end
   end

   // one quotient bit per stage for both axes; the first stage also forms the destination offset
   for (genvar j = 1; j <= QUO_W; j++) begin : g_div
      div_step_type step_x, step_y;

      always_comb begin
         step_x          = div_step(div_ff[j-1].rx, div_ff[j-1].qx, dw_eff);
         step_y          = div_step(div_ff[j-1].ry, div_ff[j-1].qy, dh_eff);
         div_in[j].err   = div_ff[j-1].err;
         div_in[j].rx    = step_x.rem;
         div_in[j].qx    = step_x.quo;
         div_in[j].ry    = step_y.rem;
         div_in[j].qy    = step_y.quo;
         div_in[j].lin   = div_ff[j-1].lin;
         if (j == 1) begin
            div_in[j].doff = OFF_W'(OFF_W'(div_ff[j-1].lin) * OFF_W'(pb_eff));
         end else begin
            div_in[j].doff = div_ff[j-1].doff;
         end
      end

      always_ff @(posedge clock) begin
         if (en[ST_DIV+j]) begin
            div_ff[j] <= div_in[j];
         end
      end
   end

   // source linear index and offsets
   always_comb begin
      smul_in.err  = div_ff[QUO_W].err;
      smul_in.sx   = div_ff[QUO_W].qx;
      smul_in.sy   = div_ff[QUO_W].qy;
      smul_in.slin = SLIN_W'(div_ff[QUO_W].qy) * SLIN_W'(sw_eff);
      smul_in.doff = div_ff[QUO_W].doff;

      sadd_in      = smul_ff;
      sadd_in.slin = smul_ff.slin + SLIN_W'(smul_ff.sx);

      if (sadd_ff.err) begin
         out_in = '0;
      end else begin
         out_in.sx   = sadd_ff.sx[COORD_W-1:0];
         out_in.sy   = sadd_ff.sy[COORD_W-1:0];
         out_in.soff = OFF_W'(OFF_W'(sadd_ff.slin) * OFF_W'(pb_eff));
         out_in.doff = sadd_ff.doff;
      end
      out_in.err = sadd_ff.err;
   end

   always_ff @(posedge clock) begin
      if (en[ST_SMUL]) begin
         smul_ff <= smul_in;
      end
      if (en[ST_SADD]) begin
         sadd_ff <= sadd_in;
      end
      if (en[ST_OUT]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = vld_ff[ST_OUT];
   assign rsp_tuser  = out_ff.err;
   assign rsp_tdata  = {(RSP_DATA_W - 2*COORD_W - 2*OFF_W)'(0), out_ff.doff, out_ff.soff,
                        out_ff.sy, out_ff.sx};

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("error item carries nonzero fields");

   a_src_x_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_SMUL] && !smul_ff.err |-> smul_ff.sx < sw_eff && smul_ff.sy < sh_eff)
      else $error("source coordinate beyond source size");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("pipeline refuses items with empty output");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_OUT] && !rsp_tready |=> vld_ff[ST_OUT] && $stable(out_ff))
      else $error("stalled output stage changed");

endmodule
